// File: rtl/bhsa_pkg.sv
// ----------------------------------------------------------------------------
// bhsa_pkg
// Types, codes and small helper functions for the bitmap slot heap.
// ----------------------------------------------------------------------------
package bhsa_pkg;

    localparam int WORD_BITS = 32;

    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_SET   = 3'd2;
    localparam logic [2:0] CMD_FREE  = 3'd3;
    localparam logic [2:0] CMD_QUERY = 3'd4;
    localparam logic [2:0] CMD_SWEEP = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  slot_index;
        logic [31:0] payload;
        logic        pinned;
        logic        sweep_all;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  result_index;
        logic [31:0] read_payload;
        logic        is_allocated;
        logic        is_marked;
        logic        is_pinned;
        logic [10:0] released_count;
    } rsp_t;

    // One bitmap word: 32 slots with their pinned, mark and allocation bits.
    typedef struct packed {
        logic [WORD_BITS-1:0] pin;
        logic [WORD_BITS-1:0] mark;
        logic [WORD_BITS-1:0] alloc;
    } bmw_t;

    // Returns {found, position} of the lowest clear bit.
    function automatic logic [5:0] lowest_clear(input logic [WORD_BITS-1:0] bits);
        logic [5:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!bits[i])
            begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] bits);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + {3'd0, bits[i]};
        end
        return s;
    endfunction

    function automatic logic [5:0] popcount32(input logic [WORD_BITS-1:0] bits);
        logic [4:0] lo;
        logic [4:0] hi;
        lo = {1'b0, pop8(bits[7:0])} + {1'b0, pop8(bits[15:8])};
        hi = {1'b0, pop8(bits[23:16])} + {1'b0, pop8(bits[31:24])};
        return {1'b0, lo} + {1'b0, hi};
    endfunction

endpackage

// File: rtl/bhsa_ram.sv
// ----------------------------------------------------------------------------
// bhsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bhsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/bitmap_heap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_heap_slot_allocator
// Slot heap with first-fit allocation over bitmap words and mark/sweep release.
// ----------------------------------------------------------------------------
// Load, set, free and query pass through S_EVAL; unknown commands are answered from S_IDLE.
// Alloc scans one bitmap word per cycle from word 0 until it finds a clear bit or the last word.
// Sweep visits every bitmap word, one word per cycle (NWORDS = CAPACITY/32
// rounded up). One command at a time; the result strobe cannot be stalled.
// After reset the bitmap memory is cleared word by word with busy high.
module bitmap_heap_slot_allocator #(
    parameter int CAPACITY     = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bhsa_pkg::req_t  request,
    output logic            done,
    output bhsa_pkg::rsp_t  result
);

    localparam int NWORDS    = (CAPACITY + bhsa_pkg::WORD_BITS - 1) / bhsa_pkg::WORD_BITS;
    localparam int WW        = NWORDS > 1 ? $clog2(NWORDS) : 1;
    localparam int SW        = $clog2(CAPACITY);
    localparam int CW        = $clog2(CAPACITY + 1);
    localparam int PW        = PAYLOAD_BITS < 32 ? PAYLOAD_BITS : 32;
    localparam int LAST_BITS = CAPACITY - (NWORDS - 1) * bhsa_pkg::WORD_BITS;
    localparam logic [31:0] LAST_MASK = 32'((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [WW-1:0] LAST_WORD = WW'(NWORDS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [WW-1:0]  ptr_reg, ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    bhsa_pkg::req_t req_reg, req_next;
    logic           done_reg, done_next;
    bhsa_pkg::rsp_t rsp_reg, rsp_next;

    logic           bm_we;
    logic [WW-1:0]  bm_waddr, bm_raddr;
    bhsa_pkg::bmw_t bm_wdata, bm_rdata;
    logic           pl_we;
    logic [SW-1:0]  pl_waddr, pl_raddr;
    logic [PW-1:0]  pl_wdata, pl_rdata;

    bhsa_ram #(
        .WIDTH ($bits(bhsa_pkg::bmw_t)),
        .DEPTH (NWORDS)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bhsa_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    logic [16:0]    live_idx, held_idx;
    logic [4:0]     held_bit;
    logic           held_in_range;
    logic [31:0]    search_bits;
    logic [5:0]     free_pos;
    logic [31:0]    release_bits;
    logic [CW-1:0]  count_sum;
    bhsa_pkg::bmw_t word_mod;

    assign live_idx      = 17'(request.slot_index);
    assign held_idx      = 17'(req_reg.slot_index);
    assign held_bit      = held_idx[4:0];
    assign held_in_range = held_idx < 17'(CAPACITY);
    assign search_bits   = bm_rdata.alloc | ((ptr_reg == LAST_WORD) ? ~LAST_MASK : 32'd0);
    assign free_pos      = bhsa_pkg::lowest_clear(search_bits);
    assign release_bits  = bm_rdata.mark & (~bm_rdata.pin | {32{req_reg.sweep_all}});
    assign count_sum     = count_reg + CW'(bhsa_pkg::popcount32(release_bits));

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        req_next   = req_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        bm_we      = 1'b0;
        bm_waddr   = ptr_reg;
        bm_wdata   = '0;
        bm_raddr   = WW'(live_idx >> 5);
        pl_we      = 1'b0;
        pl_waddr   = SW'(held_idx);
        pl_wdata   = PW'(req_reg.payload);
        pl_raddr   = SW'(live_idx);
        word_mod   = bm_rdata;

        unique case (state_reg)
            S_CLEAR:
            begin
                bm_we    = 1'b1;
                ptr_next = ptr_reg + WW'(1);
                if (ptr_reg == LAST_WORD)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    ptr_next   = '0;
                    count_next = '0;
                    unique case (request.cmd) inside
                        bhsa_pkg::CMD_ALLOC:
                        begin
                            bm_raddr   = '0;
                            state_next = S_ALLOC;
                        end
                        bhsa_pkg::CMD_SWEEP:
                        begin
                            bm_raddr   = '0;
                            state_next = S_SWEEP;
                        end
                        bhsa_pkg::CMD_LOAD, bhsa_pkg::CMD_SET,
                        bhsa_pkg::CMD_FREE, bhsa_pkg::CMD_QUERY:
                        begin
                            state_next = S_EVAL;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '0;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                bm_raddr = (ptr_reg == LAST_WORD) ? ptr_reg : ptr_reg + WW'(1);
                ptr_next = ptr_reg + WW'(1);
                if (free_pos[5])
                begin
                    word_mod.alloc[free_pos[4:0]] = 1'b1;
                    word_mod.mark[free_pos[4:0]]  = 1'b1;
                    word_mod.pin[free_pos[4:0]]   = req_reg.pinned;
                    bm_we      = 1'b1;
                    bm_wdata   = word_mod;
                    pl_we      = 1'b1;
                    pl_waddr   = SW'({ptr_reg, free_pos[4:0]});
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    rsp_next.status       = bhsa_pkg::ST_OK;
                    rsp_next.result_index = 10'({ptr_reg, free_pos[4:0]});
                    state_next = S_IDLE;
                end
                else if (ptr_reg == LAST_WORD)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    rsp_next.status = bhsa_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                bm_raddr   = (ptr_reg == LAST_WORD) ? ptr_reg : ptr_reg + WW'(1);
                ptr_next   = ptr_reg + WW'(1);
                count_next = count_sum;
                word_mod.mark  = bm_rdata.mark & ~release_bits;
                word_mod.alloc = bm_rdata.alloc & ~release_bits;
                bm_we    = 1'b1;
                bm_wdata = word_mod;
                if (ptr_reg == LAST_WORD)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    rsp_next.status         = bhsa_pkg::ST_OK;
                    rsp_next.released_count = 11'(count_sum);
                    state_next = S_IDLE;
                end
            end
            S_EVAL:
            begin
                bm_waddr   = WW'(held_idx >> 5);
                done_next  = 1'b1;
                rsp_next   = '0;
                state_next = S_IDLE;
                if (!held_in_range)
                begin
                    rsp_next.status = bhsa_pkg::ST_NULL;
                end
                else if (req_reg.cmd == bhsa_pkg::CMD_QUERY)
                begin
                    rsp_next.is_allocated = bm_rdata.alloc[held_bit];
                    rsp_next.is_marked    = bm_rdata.mark[held_bit];
                    rsp_next.is_pinned    = bm_rdata.alloc[held_bit] & bm_rdata.pin[held_bit];
                end
                else if (!bm_rdata.alloc[held_bit])
                begin
                    rsp_next.status = bhsa_pkg::ST_NULL;
                end
                else if (req_reg.cmd == bhsa_pkg::CMD_LOAD)
                begin
                    rsp_next.read_payload = 32'(pl_rdata);
                end
                else if (req_reg.cmd == bhsa_pkg::CMD_SET)
                begin
                    word_mod.pin[held_bit] = req_reg.pinned;
                    bm_we    = 1'b1;
                    bm_wdata = word_mod;
                    pl_we    = 1'b1;
                end
                else
                begin
                    word_mod.alloc[held_bit] = 1'b0;
                    bm_we    = 1'b1;
                    bm_wdata = word_mod;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

endmodule

// File: tb/tb_bitmap_heap_slot_allocator.sv
// ----------------------------------------------------------------------------
// tb_bitmap_heap_slot_allocator
// Self-checking regression for the bitmap slot heap. A short directed table
// walks empty-heap errors, first-fit reuse, pinned slots, unknown commands, a
// full heap and a sweep of every slot. A random command mix follows under
// several sender gap settings. Every result word is checked field by field
// against its table row's word or a behavioral heap model in the testbench.
// ----------------------------------------------------------------------------
module tb_bitmap_heap_slot_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_SLOTS  = 1024;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_WORDS  = 63;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        bhsa_pkg::req_t rq;
        int             reps;
        bit             typed;
        bhsa_pkg::rsp_t want;
    } plan_row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bhsa_pkg::req_t request;
    logic           done;
    bhsa_pkg::rsp_t result;

    bit          slot_used [HEAP_SLOTS];
    bit          slot_mark [HEAP_SLOTS];
    logic [31:0] slot_word [HEAP_SLOTS];
    bit          slot_pin  [HEAP_SLOTS];

    bhsa_pkg::rsp_t pending_rsp [$];
    bhsa_pkg::rsp_t want_w;
    bit             cur_typed;
    bhsa_pkg::rsp_t cur_want;

    int gap_pct;
    int err_count;
    int quiet_cycles;
    int n_words;
    int n_results;
    int n_allocs;
    int n_full;
    int n_sweeps;
    int max_released;

    plan_row_t plan [28];

    bitmap_heap_slot_allocator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bhsa_pkg::rsp_t mk_rsp(input logic [1:0] st, input logic [9:0] ridx,
                                              input logic [31:0] rpay, input bit a,
                                              input bit m, input bit p,
                                              input logic [10:0] cnt);
        bhsa_pkg::rsp_t r;
        r.status         = st;
        r.result_index   = ridx;
        r.read_payload   = rpay;
        r.is_allocated   = a;
        r.is_marked      = m;
        r.is_pinned      = p;
        r.released_count = cnt;
        return r;
    endfunction

    function automatic plan_row_t mk_row(input logic [2:0] c, input logic [9:0] idx,
                                         input logic [31:0] pay, input bit pin,
                                         input bit all, input int reps, input bit typed,
                                         input bhsa_pkg::rsp_t want);
        plan_row_t row;
        row.rq.cmd        = c;
        row.rq.slot_index = idx;
        row.rq.payload    = pay;
        row.rq.pinned     = pin;
        row.rq.sweep_all  = all;
        row.reps          = reps;
        row.typed         = typed;
        row.want          = want;
        return row;
    endfunction

    function automatic bhsa_pkg::rsp_t heap_step(input bhsa_pkg::req_t rq);
        bhsa_pkg::rsp_t r;
        bit             hit;
        int             i;
        r   = '0;
        hit = 1'b0;
        case (rq.cmd)
            bhsa_pkg::CMD_ALLOC:
            begin
                r.status = bhsa_pkg::ST_FULL;
                for (i = 0; i < HEAP_SLOTS && !hit; i++)
                begin
                    if (!slot_used[i])
                    begin
                        slot_word[i]   = rq.payload;
                        slot_pin[i]    = rq.pinned;
                        slot_used[i]   = 1'b1;
                        slot_mark[i]   = 1'b1;
                        r.result_index = 10'(i);
                        r.status       = bhsa_pkg::ST_OK;
                        hit            = 1'b1;
                    end
                end
            end
            bhsa_pkg::CMD_LOAD:
            begin
                if (slot_used[rq.slot_index])
                    r.read_payload = slot_word[rq.slot_index];
                else
                    r.status = bhsa_pkg::ST_NULL;
            end
            bhsa_pkg::CMD_SET:
            begin
                if (slot_used[rq.slot_index])
                begin
                    slot_word[rq.slot_index] = rq.payload;
                    slot_pin[rq.slot_index]  = rq.pinned;
                end
                else
                begin
                    r.status = bhsa_pkg::ST_NULL;
                end
            end
            bhsa_pkg::CMD_FREE:
            begin
                if (slot_used[rq.slot_index])
                    slot_used[rq.slot_index] = 1'b0;
                else
                    r.status = bhsa_pkg::ST_NULL;
            end
            bhsa_pkg::CMD_QUERY:
            begin
                r.is_allocated = slot_used[rq.slot_index];
                r.is_marked    = slot_mark[rq.slot_index];
                r.is_pinned    = slot_used[rq.slot_index] && slot_pin[rq.slot_index];
            end
            bhsa_pkg::CMD_SWEEP:
            begin
                for (i = 0; i < HEAP_SLOTS; i++)
                begin
                    if (slot_mark[i] && (!slot_pin[i] || rq.sweep_all))
                    begin
                        slot_mark[i]     = 1'b0;
                        slot_used[i]     = 1'b0;
                        r.released_count = r.released_count + 11'd1;
                    end
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    task automatic check_rsp(input bhsa_pkg::rsp_t got, input bhsa_pkg::rsp_t want);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
        end
        if (got.result_index !== want.result_index)
        begin
            $error("result_index: expected %0d, got %0d", want.result_index,
                   got.result_index);
            err_count++;
        end
        if (got.read_payload !== want.read_payload)
        begin
            $error("read_payload: expected %08h, got %08h", want.read_payload,
                   got.read_payload);
            err_count++;
        end
        if (got.is_allocated !== want.is_allocated)
        begin
            $error("is_allocated: expected %0b, got %0b", want.is_allocated,
                   got.is_allocated);
            err_count++;
        end
        if (got.is_marked !== want.is_marked)
        begin
            $error("is_marked: expected %0b, got %0b", want.is_marked, got.is_marked);
            err_count++;
        end
        if (got.is_pinned !== want.is_pinned)
        begin
            $error("is_pinned: expected %0b, got %0b", want.is_pinned, got.is_pinned);
            err_count++;
        end
        if (got.released_count !== want.released_count)
        begin
            $error("released_count: expected %0d, got %0d", want.released_count,
                   got.released_count);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1 || (start && busy === 1'b0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (done === 1'b1)
            begin
                n_results++;
                if (pending_rsp.size() == 0)
                begin
                    $error("result word with no command outstanding");
                    err_count++;
                end
                else
                begin
                    check_rsp(result, pending_rsp.pop_front());
                end
            end
            if (start && busy === 1'b0)
            begin
                n_words++;
                want_w = heap_step(request);
                if (request.cmd == bhsa_pkg::CMD_ALLOC)
                begin
                    n_allocs++;
                    if (want_w.status == bhsa_pkg::ST_FULL)
                        n_full++;
                end
                if (request.cmd == bhsa_pkg::CMD_SWEEP)
                begin
                    n_sweeps++;
                    if (int'(want_w.released_count) > max_released)
                        max_released = int'(want_w.released_count);
                end
                if (cur_typed)
                    want_w = cur_want;
                pending_rsp.push_back(want_w);
            end
        end
    end

    task automatic send_word(input bhsa_pkg::req_t rq, input bit typed,
                             input bhsa_pkg::rsp_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        request   <= rq;
        cur_typed = typed;
        cur_want  = want;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    function automatic logic [9:0] pick_slot();
        int hi;
        int i;
        int roll;
        hi = 0;
        for (i = 0; i < HEAP_SLOTS; i++)
        begin
            if (slot_used[i] || slot_mark[i])
                hi = i;
        end
        roll = $urandom_range(99);
        if (roll < 75)
            return 10'($urandom_range(0, (hi < HEAP_SLOTS - 1) ? hi + 1 : hi));
        else if (roll < 90)
            return 10'($urandom_range(0, HEAP_SLOTS - 1));
        else
            return ($urandom_range(1) != 0) ? 10'd1023 : 10'd0;
    endfunction

    function automatic bhsa_pkg::req_t rand_word();
        bhsa_pkg::req_t rq;
        int             roll;
        roll          = $urandom_range(99);
        rq.slot_index = pick_slot();
        rq.payload    = $urandom();
        if ($urandom_range(9) == 0)
            rq.payload = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        rq.pinned     = ($urandom_range(99) < 30);
        rq.sweep_all  = ($urandom_range(99) < 40);
        if (roll < 30)
            rq.cmd = bhsa_pkg::CMD_ALLOC;
        else if (roll < 45)
            rq.cmd = bhsa_pkg::CMD_LOAD;
        else if (roll < 57)
            rq.cmd = bhsa_pkg::CMD_SET;
        else if (roll < 72)
            rq.cmd = bhsa_pkg::CMD_FREE;
        else if (roll < 88)
            rq.cmd = bhsa_pkg::CMD_QUERY;
        else if (roll < 96)
            rq.cmd = bhsa_pkg::CMD_SWEEP;
        else
            rq.cmd = 3'($urandom_range(6, 7));
        return rq;
    endfunction

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("bitmap_heap_slot_allocator regression: fail");
        $finish;
    end

    initial
    begin
        bhsa_pkg::req_t rq;
        int             r;
        int             k;
        int             ph;
        int             gaps [4];

        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        cur_typed    = 1'b0;
        cur_want     = '0;
        gap_pct      = 0;
        err_count    = 0;
        quiet_cycles = 0;
        n_words      = 0;
        n_results    = 0;
        n_allocs     = 0;
        n_full       = 0;
        n_sweeps     = 0;
        max_released = 0;
        gaps         = '{0, 57, 0, 33};
        for (k = 0; k < HEAP_SLOTS; k++)
        begin
            slot_used[k] = 1'b0;
            slot_mark[k] = 1'b0;
            slot_word[k] = '0;
            slot_pin[k]  = 1'b0;
        end

        plan = '{
            mk_row(bhsa_pkg::CMD_QUERY, 10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_LOAD,  10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_NULL, 10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_SET,   10'd5,    32'hDEAD_BEEF, 1, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_NULL, 10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_FREE,  10'd1023, 32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_NULL, 10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_SWEEP, 10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_ALLOC, 10'd0,    32'hFFFF_FFFF, 1, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_ALLOC, 10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd1, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_LOAD,  10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'hFFFF_FFFF, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_QUERY, 10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 1, 1, 1, 11'd0)),
            mk_row(bhsa_pkg::CMD_SET,   10'd1,    32'hA5A5_A5A5, 1, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_LOAD,  10'd1,    32'h0,         0, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_FREE,  10'd0,    32'h0,         0, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_QUERY, 10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 1, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_FREE,  10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_NULL, 10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_ALLOC, 10'd0,    32'h1234_5678, 0, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_FREE,  10'd0,    32'h0,         0, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_SWEEP, 10'd0,    32'h0,         0, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_QUERY, 10'd1,    32'h0,         0, 0, 1, 0, '0),
            mk_row(3'd6,                10'd1023, 32'hFFFF_FFFF, 1, 1, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(3'd7,                10'd1,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_SWEEP, 10'd0,    32'h0,         0, 1, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_ALLOC, 10'd0,    32'h0,         0, 0, HEAP_SLOTS, 0, '0),
            mk_row(bhsa_pkg::CMD_ALLOC, 10'd0,    32'h5555_AAAA, 1, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_FULL, 10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_LOAD,  10'd1023, 32'h0,         0, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_QUERY, 10'd1023, 32'h0,         0, 0, 1, 0, '0),
            mk_row(bhsa_pkg::CMD_SWEEP, 10'd0,    32'h0,         0, 1, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd1024)),
            mk_row(bhsa_pkg::CMD_QUERY, 10'd1023, 32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd0)),
            mk_row(bhsa_pkg::CMD_ALLOC, 10'd0,    32'h0,         0, 0, 1, 1,
                   mk_rsp(bhsa_pkg::ST_OK,   10'd0, 32'h0, 0, 0, 0, 11'd0))
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < $size(plan); r++)
        begin
            for (k = 0; k < plan[r].reps; k++)
            begin
                rq = plan[r].rq;
                if (plan[r].reps > 1)
                begin
                    rq.payload = $urandom();
                    rq.pinned  = $urandom_range(1);
                end
                send_word(rq, plan[r].typed, plan[r].want);
            end
        end

        for (ph = 0; ph < 4; ph++)
        begin
            gap_pct = gaps[ph];
            for (k = 0; k < RAND_WORDS; k++)
                send_word(rand_word(), 1'b0, '0);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Issued %0d commands: %0d allocs (%0d refused on a full heap), %0d sweeps.",
                 n_words, n_allocs, n_full, n_sweeps);
        $display("Largest sweep released %0d slots; %0d result words seen, %0d mismatches.",
                 max_released, n_results, err_count);
        if (err_count == 0 && pending_rsp.size() == 0)
            $display("bitmap_heap_slot_allocator regression: pass");
        else
            $display("bitmap_heap_slot_allocator regression: fail");
        $finish;
    end

endmodule
